>>> rtl/core/sfcd_pkg.sv
// shared types, state codes and crc step for the sensor frame decoder
`default_nettype none

package sfcd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // one input beat
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic              frame_ok;
    logic [5:0]        sensor_id;
    logic signed [11:0] temperature_tenths;
    logic              battery_low;
    logic [6:0]        humidity_percent;
  } out_beat_t;

  // frame tracker position, one-hot
  typedef enum logic [4:0] {
    POS_IDLE = 5'b00001,
    POS_B1   = 5'b00010,
    POS_B2   = 5'b00100,
    POS_B3   = 5'b01000,
    POS_B4   = 5'b10000
  } pos_t;

  // held frame contents and control toward the decoder
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       crc_ok;
    logic       emit;
  } frame_view_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfcd_frame.sv
// frame tracker: byte position, running crc and held frame bytes
`default_nettype none

module sfcd_frame (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire sfcd_pkg::in_beat_t  beat,
  output sfcd_pkg::frame_view_t    view
);
  import sfcd_pkg::*;

  pos_t       pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] held_r [4];

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (beat.frame_start) begin
        pos_nxt = POS_B1;
        crc_nxt = crc8_step(8'h00, beat.rx_byte);
      end else begin
        case (pos_r)
          POS_B1: begin
            pos_nxt = POS_B2;
            crc_nxt = crc8_step(crc_r, beat.rx_byte);
          end
          POS_B2: begin
            pos_nxt = POS_B3;
            crc_nxt = crc8_step(crc_r, beat.rx_byte);
          end
          POS_B3: begin
            pos_nxt = POS_B4;
            crc_nxt = crc8_step(crc_r, beat.rx_byte);
          end
          POS_B4: begin
            pos_nxt = POS_IDLE;
          end
          default: begin
            pos_nxt = POS_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      crc_r <= 8'h00;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // held bytes, each at its own slot
  always_ff @(posedge clk) begin
    if (accept) begin
      if (beat.frame_start) begin
        held_r[0] <= beat.rx_byte;
      end else if (pos_r == POS_B1) begin
        held_r[1] <= beat.rx_byte;
      end else if (pos_r == POS_B2) begin
        held_r[2] <= beat.rx_byte;
      end else if (pos_r == POS_B3) begin
        held_r[3] <= beat.rx_byte;
      end
    end
  end

  always_comb begin
    view.b0     = held_r[0];
    view.b1     = held_r[1];
    view.b2     = held_r[2];
    view.b3     = held_r[3];
    view.crc_ok = (beat.rx_byte == crc_r);
    view.emit   = accept && !beat.frame_start && (pos_r == POS_B4);
  end

`ifndef SYNTH
  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    accept && beat.frame_start |=> pos_r == POS_B1)
    else $error("start beat did not open a frame");

  a_check_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !beat.frame_start && pos_r == POS_B4 |=> pos_r == POS_IDLE)
    else $error("frame not closed after check byte");

  a_idle_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !beat.frame_start && pos_r == POS_IDLE |=> pos_r == POS_IDLE && $stable(crc_r))
    else $error("stray beat disturbed idle tracker");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sfcd_decode.sv
// field decode of a checked frame
`default_nettype none

module sfcd_decode (
  input  wire sfcd_pkg::frame_view_t view,
  output sfcd_pkg::out_beat_t        result
);
  import sfcd_pkg::*;

  logic [10:0] bcd_sum;
  logic [11:0] temp_raw;

  // tens, units, tenths; nibbles above nine taken at face value
  always_comb begin
    bcd_sum  = 11'(view.b1[3:0]) * 11'd100 + 11'(view.b2[7:4]) * 11'd10
             + 11'(view.b2[3:0]);
    temp_raw = 12'(bcd_sum) - 12'd400;
  end

  always_comb begin
    result = '0;
    if (view.crc_ok) begin
      result.frame_ok           = 1'b1;
      result.sensor_id          = {view.b0[3:0], view.b1[7:6]};
      result.temperature_tenths = $signed(temp_raw);
      result.battery_low        = view.b3[7];
      result.humidity_percent   = view.b3[6:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sensor_frame_crc_decoder.sv
// top level of the crc-checked sensor frame decoder
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------
//   in_     | in  | in_valid/in_stall  | in_data: rx_byte, frame_start
//   out_    | out | out_valid/out_stall| out_data: ok, id, temp, batt, humid
//
// one beat per cycle while in_stall is low; the result appears in the cycle after
// the check byte is taken, held in the output register
// in_stall rises only while a result waits in the output register and
// out_stall is high; otherwise every cycle with in_valid high takes a beat
// rst_n (synchronous) closes any open frame and clears the crc and the
// output register valid; held bytes carry no reset
`default_nettype none

module sensor_frame_crc_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sfcd_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sfcd_pkg::out_beat_t      out_data
);
  import sfcd_pkg::*;

  logic        in_accept;
  logic        out_free;
  frame_view_t view;
  out_beat_t   result;

  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_data_r;

  // output register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && !in_stall;

  // byte tracker and crc
  sfcd_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .beat   (in_data),
    .view   (view)
  );

  // field extraction, zeroed on crc mismatch
  sfcd_decode u_decode (
    .view   (view),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = view.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only loads with a new result
  always_ff @(posedge clk) begin
    if (out_free && view.emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.frame_ok |->
      out_data_r.sensor_id == 6'd0 && out_data_r.temperature_tenths == 12'sd0 &&
      !out_data_r.battery_low && out_data_r.humidity_percent == 7'd0)
    else $error("failed frame carries nonzero fields");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with empty output register");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    view.emit |=> out_valid_r)
    else $error("check byte taken but no result shown");
`endif

endmodule

`default_nettype wire
